// ----- hdl/ctsmp_pkg.sv -----
package ctsmp_pkg;

   localparam int MaxEntries = 1024;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = IdxW + 1;

   typedef enum logic [1:0] {
      CMD_SAMPLE     = 2'd0,
      CMD_SAMPLE_ADD = 2'd1,
      CMD_ADD        = 2'd2,
      CMD_RSVD       = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_ZERO_DIV = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   localparam logic [0:0] REG_CONCENTRATION = 1'b0;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture transaction, start division
      logic div_step;    // one restoring division step
      logic walk_rd;     // issue RAM read at walk index
      logic walk_acc;    // accumulate read data
      logic add_rd;      // issue RAM read at target index
      logic add_wr;      // write target (increment or set 1)
      logic clr_wr;      // write zero at gap index
      logic clr_next;    // advance gap index
      logic use_pick;    // target := picked index
      logic set_status;  // latch status from status_in
      status_type status_in;
      logic commit;      // update entries_used / total
      logic respond;     // pulse result strobe
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    div_zero;
      logic    div_done;
      logic    walk_hit;
      logic    walk_end;
      logic    tgt_full;
      logic    tgt_new;
      logic    total_max;
      logic    entry_max;
      logic    gap_done;
   } sts_type;

endpackage

// ----- hdl/crp_count_table_sampler_top.sv -----
// Count-table sampler for a Chinese restaurant process. Pulse start while busy
// is low to launch one transaction; exactly one result follows, shown for a
// single cycle with rsp_valid high. The receiver cannot stall, so sample it
// then. Steps after the accepting edge: a check, the division (one restoring
// step per bit of the 31-bit random word), a walk of the table with a RAM
// read then an accumulate per entry (up to 1024 entries), and a pick; an add
// (alone for CMD_ADD, which skips division and walk, or after the pick) then
// reads, waits, decides, clears any gap entries up to a new target and writes;
// a full target or an overflow skips the write. A last step raises the strobe.
// A zero divisor goes straight from the check to the strobe. After reset a
// clearing pass over all 1024 entries zeroes the count RAM; busy stays high
// during it. concentration is at APB address 0 and may be written any time
// the block is idle.
module crp_count_table_sampler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [30:0] req_random_value,
   input  logic [9:0]  req_add_index,
   output logic        rsp_valid,
   output logic [10:0] rsp_picked_index,
   output logic        rsp_is_new,
   output logic [1:0]  rsp_status,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [0:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   ctsmp_pkg::ctl_type ctl;
   ctsmp_pkg::sts_type sts;
   logic [15:0] conc_ff;
   logic        clr_busy;

   // configuration register; paddr holds byte address bit 2 only
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         conc_ff <= 16'd1;
      end else if (psel && penable && pwrite && paddr == ctsmp_pkg::REG_CONCENTRATION) begin
         conc_ff <= pwdata[15:0];
      end
   end
   assign prdata = (paddr == ctsmp_pkg::REG_CONCENTRATION) ? {16'b0, conc_ff} : 32'b0;

   ctsmp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .clr_busy(clr_busy),
      .sts(sts), .ctl(ctl), .busy(busy)
   );

   ctsmp_datapath u_dp (
      .clock(clock), .reset(reset), .ctl(ctl), .sts(sts),
      .req_cmd(req_cmd), .req_random_value(req_random_value),
      .req_add_index(req_add_index), .concentration(conc_ff),
      .rsp_picked_index(rsp_picked_index), .rsp_is_new(rsp_is_new),
      .rsp_status(rsp_status), .rsp_valid(rsp_valid), .clr_busy(clr_busy)
   );

   // one result per transaction: a strobe only when busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without transaction");
   // the strobe lasts a single cycle
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result strobe");
   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ctsmp_pkg::ST_ZERO_DIV |-> rsp_picked_index == 11'd0)
      else $error("zero divisor with nonzero index");
endmodule

// ----- hdl/ctsmp_ram.sv -----
module ctsmp_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end
   assign rdata = rdata_ff;
endmodule

// ----- hdl/ctsmp_datapath.sv -----
module ctsmp_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  ctsmp_pkg::ctl_type       ctl,
   output ctsmp_pkg::sts_type       sts,
   input  logic [1:0]               req_cmd,
   input  logic [30:0]              req_random_value,
   input  logic [ctsmp_pkg::IdxW-1:0] req_add_index,
   input  logic [15:0]              concentration,
   output logic [ctsmp_pkg::CntW-1:0] rsp_picked_index,
   output logic                     rsp_is_new,
   output logic [1:0]               rsp_status,
   output logic                     rsp_valid,
   output logic                     clr_busy
);
   localparam int IdxW = ctsmp_pkg::IdxW;
   localparam int CntW = ctsmp_pkg::CntW;

   logic [1:0]      cmd_ff;
   logic [32:0]     div_ff;      // divisor total+alpha
   logic [32:0]     rem_ff, rem_in;
   logic [30:0]     quo_ff;      // dividend shifts out MSB first
   logic [4:0]      dcnt_ff;
   logic [CntW-1:0] used_ff;
   logic [31:0]     total_ff;
   logic [CntW-1:0] walk_ff;     // index being read
   logic [CntW-1:0] pick_ff;
   logic [33:0]     run_ff;
   logic [CntW-1:0] tgt_ff;
   logic [CntW-1:0] gap_ff;
   logic            new_ff;
   logic [1:0]      status_ff;
   logic            valid_ff;
   logic [CntW-1:0] clr_ff;      // reset sweep counter
   logic            clr_busy_ff;
   logic            we;
   logic [IdxW-1:0] addr;
   logic [31:0]     wdata, rdata;
   logic [33:0]     run_sum;
   logic [33:0]     sub;

   ctsmp_ram #(.Width(32), .Depth(ctsmp_pkg::MaxEntries)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
   );

   assign run_sum = run_ff + {2'b0, rdata};
   assign rem_in  = {rem_ff[31:0], quo_ff[30]};
   assign sub     = {1'b0, rem_in} - {1'b0, div_ff};

   always_comb begin
      we    = 1'b0;
      addr  = walk_ff[IdxW-1:0];
      wdata = rdata + 32'd1;
      if (clr_busy_ff) begin
         we = 1'b1; addr = clr_ff[IdxW-1:0]; wdata = '0;
      end else if (ctl.clr_wr) begin
         we = 1'b1; addr = gap_ff[IdxW-1:0]; wdata = '0;
      end else if (ctl.add_rd || ctl.add_wr) begin
         addr = tgt_ff[IdxW-1:0];
         we   = ctl.add_wr;
         if (ctl.add_wr && tgt_ff >= used_ff) begin
            wdata = 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         total_ff    <= '0;
         valid_ff    <= 1'b0;
         clr_ff      <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         valid_ff <= ctl.respond;
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == CntW'(ctsmp_pkg::MaxEntries - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (ctl.commit) begin
            total_ff <= total_ff + 32'd1;
            if (tgt_ff >= used_ff) begin
               used_ff <= tgt_ff + 1'b1;
            end
         end
      end
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         div_ff  <= {1'b0, total_ff} + {17'b0, concentration};
         rem_ff  <= '0;
         quo_ff  <= req_random_value;
         dcnt_ff <= '0;
         walk_ff <= '0;
         run_ff  <= '0;
         pick_ff <= used_ff;
         tgt_ff  <= {1'b0, req_add_index};
         gap_ff  <= used_ff;
         new_ff  <= ({1'b0, req_add_index} >= used_ff);
      end
      if (ctl.div_step) begin
         rem_ff  <= sub[33] ? rem_in : sub[32:0];
         quo_ff  <= {quo_ff[29:0], 1'b0};
         dcnt_ff <= dcnt_ff + 5'd1;
      end
      if (ctl.walk_rd) begin
         walk_ff <= walk_ff + 1'b1;
      end
      if (ctl.walk_acc) begin
         run_ff <= run_sum;
         if ({1'b0, rem_ff} < run_sum) begin
            pick_ff <= walk_ff - 1'b1;
         end
      end
      if (ctl.use_pick) begin
         tgt_ff <= pick_ff;
         gap_ff <= used_ff;
         new_ff <= (pick_ff >= used_ff);
      end
      if (ctl.clr_next) begin
         gap_ff <= gap_ff + 1'b1;
      end
      if (ctl.set_status) begin
         status_ff <= ctl.status_in;
         if (ctl.status_in == ctsmp_pkg::ST_ZERO_DIV) begin
            tgt_ff <= '0;
            new_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.cmd       = ctsmp_pkg::cmd_type'(cmd_ff);
      sts.div_zero  = (div_ff == '0);
      sts.div_done  = (dcnt_ff == 5'd30);
      sts.walk_hit  = ({1'b0, rem_ff} < run_sum);
      sts.walk_end  = (walk_ff >= used_ff);
      sts.tgt_full  = (tgt_ff >= CntW'(ctsmp_pkg::MaxEntries));
      sts.tgt_new   = (tgt_ff >= used_ff);
      sts.total_max = (total_ff == 32'hFFFF_FFFF);
      sts.entry_max = (rdata == 32'hFFFF_FFFF);
      sts.gap_done  = (gap_ff >= tgt_ff);
   end

   assign rsp_picked_index = tgt_ff;
   assign rsp_is_new       = new_ff;
   assign rsp_status       = status_ff;
   assign rsp_valid        = valid_ff;
   assign clr_busy         = clr_busy_ff;
endmodule

// ----- hdl/ctsmp_ctrl.sv -----
module ctsmp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               clr_busy,
   input  ctsmp_pkg::sts_type sts,
   output ctsmp_pkg::ctl_type ctl,
   output logic               busy
);
   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_DIV, S_WRD, S_WACC, S_PICK, S_ARD, S_AWAIT,
      S_ADEC, S_GAP, S_AWR, S_RESP
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE:  if (start && !clr_busy) state_ff <= S_CHECK;
            S_CHECK: begin
               if (sts.cmd == ctsmp_pkg::CMD_ADD) state_ff <= S_ARD;
               else if (sts.div_zero) state_ff <= S_RESP;
               else state_ff <= S_DIV;
            end
            S_DIV:   if (sts.div_done) state_ff <= S_WRD;
            S_WRD:   state_ff <= sts.walk_end ? S_PICK : S_WACC;
            S_WACC:  state_ff <= sts.walk_hit ? S_PICK : S_WRD;
            S_PICK:  state_ff <= (sts.cmd == ctsmp_pkg::CMD_SAMPLE_ADD) ? S_ARD : S_RESP;
            S_ARD:   state_ff <= S_AWAIT;
            S_AWAIT: state_ff <= S_ADEC;
            S_ADEC: begin
               if (sts.tgt_full || sts.total_max || (!sts.tgt_new && sts.entry_max))
                  state_ff <= S_RESP;
               else if (sts.tgt_new) state_ff <= S_GAP;
               else state_ff <= S_AWR;
            end
            S_GAP:   if (sts.gap_done) state_ff <= S_AWR;
            S_AWR:   state_ff <= S_RESP;
            S_RESP:  state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      ctl = '0;
      ctl.status_in = ctsmp_pkg::ST_OK;
      unique case (state_ff)
         S_IDLE:  ctl.load = start && !clr_busy;
         S_CHECK: begin
            ctl.set_status = 1'b1;
            if (sts.cmd != ctsmp_pkg::CMD_ADD && sts.div_zero)
               ctl.status_in = ctsmp_pkg::ST_ZERO_DIV;
         end
         S_DIV:   ctl.div_step = 1'b1;
         S_WRD:   ctl.walk_rd = !sts.walk_end;
         S_WACC:  ctl.walk_acc = 1'b1;
         S_PICK:  ctl.use_pick = 1'b1;
         S_ARD:   ctl.add_rd = 1'b1;
         S_AWAIT: ctl.add_rd = 1'b1;
         S_ADEC: begin
            ctl.add_rd = 1'b1;
            if (sts.tgt_full) begin
               ctl.set_status = 1'b1; ctl.status_in = ctsmp_pkg::ST_FULL;
            end else if (sts.total_max || (!sts.tgt_new && sts.entry_max)) begin
               ctl.set_status = 1'b1; ctl.status_in = ctsmp_pkg::ST_OVERFLOW;
            end
         end
         S_GAP: begin
            ctl.clr_wr   = !sts.gap_done;
            ctl.clr_next = !sts.gap_done;
         end
         S_AWR: begin
            ctl.add_wr = 1'b1;
            ctl.commit = 1'b1;
         end
         S_RESP:  ctl.respond = 1'b1;
         default: ctl = '0;
      endcase
   end

   assign busy = (state_ff != S_IDLE) || clr_busy;
endmodule
